// ----- rtl/pla_pkg.sv -----
// shared types and constants of the polyline length accumulator
`default_nettype none
package pla_pkg;

  localparam int COORD_W  = 16;
  localparam int SEG_W    = 25;
  localparam int TOTAL_W  = 36;

  localparam int COORD_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [SEG_W-1:0]   SEG_MAX   = {SEG_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // one classified point waiting for the length unit
  typedef struct packed {
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               first;
    logic               last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- rtl/polyline_length_accumulator.sv -----
// polyline length accumulator: per-segment euclidean length and running route total
//
// input channel: push with x_coord, y_coord, last_point; a word is taken when push
// is high and full is low. result channel: segment_length, route_total, route_done
// are valid while empty is low and are taken when pop is high.
// every input word gives exactly one result word, in order. the first point of a
// route gives length 0 and total 0; the word marked last_point closes the route
// and the next word starts a new one.
// lengths are floor(sqrt(dx^2 + dy^2)) with FRAC_BITS fraction bits; the total
// saturates at its maximum.
// the length unit takes one word at a time: it loads the word, squares the deltas,
// sums them, runs the root loop that retires two bits per cycle, then writes the
// result register, and only then takes the next word from the queue.
// a small queue between the front end and the length unit takes up to
// QUEUE_DEPTH words while the unit is busy, so full rises only when it fills.
// if pop stays low the result register holds, the unit finishes its current word
// and waits, and the queue fills behind it.
// reset (rst, synchronous) empties the queue and result register and starts a route.
`default_nettype none
module polyline_length_accumulator #(
  parameter int COORD_BITS  = pla_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = pla_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = pla_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [pla_pkg::COORD_W-1:0]   x_coord,
  input  wire logic [pla_pkg::COORD_W-1:0]   y_coord,
  input  wire logic                          last_point,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [pla_pkg::SEG_W-1:0]          segment_length,
  output logic [pla_pkg::TOTAL_W-1:0]        route_total,
  output logic                               route_done
);

  pla_pkg::job_t    job_in;
  pla_pkg::job_t    job_out;
  pla_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  assign full = q_stat.full;

  pla_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .last_point (last_point),
    .q_stat     (q_stat),
    .job        (job_in),
    .q_push     (q_push)
  );

  pla_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (job_in),
    .rd      (q_pop),
    .rd_data (job_out),
    .stat    (q_stat)
  );

  pla_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job            (job_out),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .segment_length (segment_length),
    .route_total    (route_total),
    .route_done     (route_done)
  );

  // an accepted word is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !q_stat.empty)
    else $error("accepted word missing from queue");

  // the length unit only takes work that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("length unit read an empty queue");

  // a zero total means a zero segment, since the total includes the segment
  a_total_covers_seg: assert property (@(posedge clk) disable iff (rst)
    (!empty && (route_total == '0)) |-> (segment_length == '0))
    else $error("zero total with nonzero segment");

endmodule
`default_nettype wire

// ----- rtl/pla_front.sv -----
// front end: accepts points, keeps the previous point and forms the deltas
`default_nettype none
module pla_front #(
  parameter int COORD_BITS = pla_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [pla_pkg::COORD_W-1:0]  x_coord,
  input  wire logic [pla_pkg::COORD_W-1:0]  y_coord,
  input  wire logic                         last_point,
  input  wire pla_pkg::q_stat_t             q_stat,
  output pla_pkg::job_t                     job,
  output logic                              q_push
);

  localparam int CW = (COORD_BITS < pla_pkg::COORD_W) ? COORD_BITS : pla_pkg::COORD_W;

  logic [pla_pkg::COORD_W-1:0] prev_x;
  logic [pla_pkg::COORD_W-1:0] prev_y;
  logic                        have_prev;
  logic [pla_pkg::COORD_W-1:0] x;
  logic [pla_pkg::COORD_W-1:0] y;

  assign x      = pla_pkg::COORD_W'(x_coord[CW-1:0]);
  assign y      = pla_pkg::COORD_W'(y_coord[CW-1:0]);
  assign q_push = push && !q_stat.full;

  always_comb begin
    job.first = !have_prev;
    job.last  = last_point;
    // first point of a route has no segment
    if (!have_prev) begin
      job.dx = '0;
      job.dy = '0;
    end else begin
      job.dx = (x >= prev_x) ? (x - prev_x) : (prev_x - x);
      job.dy = (y >= prev_y) ? (y - prev_y) : (prev_y - y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else if (q_push) begin
      prev_x    <= x;
      prev_y    <= y;
      have_prev <= !last_point;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pla_queue.sv -----
// short job queue between the front end and the length unit
`default_nettype none
module pla_queue #(
  parameter int DEPTH = pla_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire pla_pkg::job_t  wr_data,
  input  wire logic           rd,
  output pla_pkg::job_t       rd_data,
  output pla_pkg::q_stat_t    stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  pla_pkg::job_t slot [DEPTH];
  pla_pkg::job_t slot_next [DEPTH];
  logic [NW-1:0] count;
  logic [PW-1:0] wr_idx;
  logic          do_wr;
  logic          do_rd;

  assign stat.full  = (count == NW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign wr_idx     = PW'(count - NW'(do_rd));
  assign rd_data    = slot[0];

  // head word always sits in slot 0; a read shifts the rest down
  always_comb begin
    slot_next = slot;
    if (do_rd) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slot_next[i] = slot[i + 1];
      end
    end
    if (do_wr) begin
      slot_next[wr_idx] = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pla_back.sv -----
// back end: squares, two-bit-per-cycle square root, saturating total, result register
`default_nettype none
module pla_back #(
  parameter int COORD_BITS = pla_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pla_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pla_pkg::job_t               job,
  input  wire pla_pkg::q_stat_t            q_stat,
  output logic                             q_pop,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [pla_pkg::SEG_W-1:0]        segment_length,
  output logic [pla_pkg::TOTAL_W-1:0]      route_total,
  output logic                             route_done
);

  localparam int CW   = (COORD_BITS < pla_pkg::COORD_W) ? COORD_BITS : pla_pkg::COORD_W;
  localparam int RB   = CW + 1 + FRAC_BITS;
  localparam int NP   = (RB + 1) / 2;
  localparam int RW   = 4 * NP;
  localparam int RTW  = 2 * NP;
  localparam int RMW  = RTW + 3;
  localparam int CNTW = $clog2(NP);
  localparam int SW   = (RTW > pla_pkg::SEG_W) ? RTW : pla_pkg::SEG_W;
  localparam int TW   = pla_pkg::TOTAL_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUM  = 5'b00100,
    S_ROOT = 5'b01000,
    S_DONE = 5'b10000
  } back_state_t;

  back_state_t         state;
  logic [CW-1:0]       dx;
  logic [CW-1:0]       dy;
  logic                first;
  logic                last;
  logic [2*CW-1:0]     sqx;
  logic [2*CW-1:0]     sqy;
  logic [RW-1:0]       rad;
  logic [RMW-1:0]      rem;
  logic [RTW-1:0]      root;
  logic [CNTW-1:0]     cnt;
  logic [TW-1:0]       total;
  logic                out_valid;

  logic [RMW-1:0]      rem_next;
  logic [RTW-1:0]      root_next;
  logic [SW-1:0]       root_ext;
  logic [pla_pkg::SEG_W-1:0] seg_sat;
  logic [TW-1:0]       base;
  logic [TW:0]         sum;
  logic [TW-1:0]       tot_new;
  logic                slot_free;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign q_pop     = (state == S_IDLE) && !q_stat.empty;

  // two restoring root steps per cycle on the top four radicand bits
  always_comb begin
    logic [RMW-1:0] trial;
    rem_next  = rem;
    root_next = root;
    for (int j = 0; j < 2; j++) begin
      rem_next = {rem_next[RMW-3:0], rad[RW-1-2*j -: 2]};
      trial    = RMW'({root_next, 2'b01});
      if (rem_next >= trial) begin
        rem_next  = rem_next - trial;
        root_next = {root_next[RTW-2:0], 1'b1};
      end else begin
        root_next = {root_next[RTW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    root_ext = SW'(root);
    seg_sat  = (root_ext > SW'(pla_pkg::SEG_MAX)) ? pla_pkg::SEG_MAX
                                                  : root_ext[pla_pkg::SEG_W-1:0];
    base     = first ? '0 : total;
    sum      = {1'b0, base} + (TW + 1)'(seg_sat);
    tot_new  = (sum > {1'b0, pla_pkg::TOTAL_MAX}) ? pla_pkg::TOTAL_MAX : sum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_ROOT;
        S_ROOT: begin
          if (cnt == CNTW'(NP - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            total <= last ? '0 : tot_new;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        dx    <= job.dx[CW-1:0];
        dy    <= job.dy[CW-1:0];
        first <= job.first;
        last  <= job.last;
      end
      S_MUL: begin
        sqx <= dx * dx;
        sqy <= dy * dy;
      end
      S_SUM: begin
        rad  <= RW'({1'b0, sqx} + {1'b0, sqy}) << (2 * FRAC_BITS);
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      S_ROOT: begin
        rad  <= {rad[RW-5:0], 4'b0000};
        rem  <= rem_next;
        root <= root_next;
        cnt  <= cnt + 1'b1;
      end
      S_DONE: begin
        if (slot_free) begin
          segment_length <= seg_sat;
          route_total    <= tot_new;
          route_done     <= last;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
